// File: hdl/layered_lightmap_bilinear_sample_macros.svh
// Assertion macros shared by the lightmap sampler RTL.
// The assertions use the clk_i and rst_ni of the module that expands them.
`ifndef LAYERED_LIGHTMAP_BILINEAR_SAMPLE_MACROS_SVH
`define LAYERED_LIGHTMAP_BILINEAR_SAMPLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge while reset is released.
`define LLBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LLBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define LLBS_ASSERT(lbl, prop, msg)
`define LLBS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hdl/llbs_pkg.sv
// Package for the layered lightmap bilinear sampler: field widths, the queued
// layer item type and the bilinear step function. No dependencies.
`timescale 1ns / 1ps

package llbs_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned NumChan      = 3;
  localparam int unsigned NumCorners   = 4;
  localparam int unsigned TexelW       = ChanW * NumChan;
  localparam int unsigned ScaleW       = 10;
  localparam int unsigned FracW        = 4;
  localparam int unsigned SumW         = 20;
  localparam int unsigned LevelW       = SumW;
  localparam int unsigned ProdW        = ChanW + ScaleW;
  localparam int unsigned DiffW        = SumW + 1;
  localparam int unsigned StepW        = DiffW + FracW;
  localparam int unsigned MaxLayersDef = 4;
  localparam int unsigned QueueDepth   = 2;

  // Corner order: top-left, top-right, bottom-left, bottom-right.
  localparam int unsigned CornerTL = 0;
  localparam int unsigned CornerTR = 1;
  localparam int unsigned CornerBL = 2;
  localparam int unsigned CornerBR = 3;

  typedef logic [SumW-1:0] sum_t;

  // One classified layer as it waits between the front and the back.
  typedef struct packed {
    logic [NumCorners-1:0][TexelW-1:0] corners;
    logic [ScaleW-1:0]                 scale;
    logic [FracW-1:0]                  s_frac;
    logic [FracW-1:0]                  t_frac;
    logic                              last;
    logic                              accum;
  } layer_t;

  // a + floor((b - a) * frac / 16); the result always lies between a and b.
  function automatic sum_t lerp(sum_t a, sum_t b, logic [FracW-1:0] frac);
    logic signed [DiffW-1:0] diff;
    logic signed [StepW-1:0] prod;
    logic signed [StepW-1:0] res;
    diff = signed'({1'b0, b}) - signed'({1'b0, a});
    prod = StepW'(diff) * StepW'(signed'({1'b0, frac}));
    res  = (prod >>> FracW) + StepW'(signed'({1'b0, a}));
    return res[SumW-1:0];
  endfunction

endpackage

// File: hdl/llbs_front.sv
// Front end of the lightmap sampler: counts the layers of the current sample
// and marks each item as accumulated or dropped. Depends on llbs_pkg.
`timescale 1ns / 1ps
`include "layered_lightmap_bilinear_sample_macros.svh"

module llbs_front #(
  parameter int unsigned MaxLayers = llbs_pkg::MaxLayersDef
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  input  logic [llbs_pkg::NumCorners-1:0][llbs_pkg::TexelW-1:0] corners_i,
  input  logic [llbs_pkg::ScaleW-1:0]                      scale_i,
  input  logic [llbs_pkg::FracW-1:0]                       s_frac_i,
  input  logic [llbs_pkg::FracW-1:0]                       t_frac_i,
  input  logic                                             last_i,
  input  logic                                             full_i,
  output logic                                             ready_o,
  output logic                                             push_o,
  output llbs_pkg::layer_t                                 entry_o
);

  localparam int unsigned CntW = $clog2(MaxLayers + 1);

  logic [CntW-1:0] layers_q, layers_d;
  logic            accum;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;
  assign accum   = layers_q < CntW'(MaxLayers);

  always_comb begin
    entry_o.corners = corners_i;
    entry_o.scale   = scale_i;
    entry_o.s_frac  = s_frac_i;
    entry_o.t_frac  = t_frac_i;
    entry_o.last    = last_i;
    entry_o.accum   = accum;
  end

  // The count restarts after the last layer of a sample.
  always_comb begin
    layers_d = layers_q;
    if (push_o) begin
      if (last_i) begin
        layers_d = '0;
      end else if (accum) begin
        layers_d = layers_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layers_q <= '0;
    end else begin
      layers_q <= layers_d;
    end
  end

  `LLBS_ASSERT(a_layers_bounded, layers_q <= CntW'(MaxLayers), "layer count beyond limit")
  `LLBS_ASSERT(a_last_restarts, push_o && last_i |=> layers_q == '0, "count not cleared")

endmodule

// File: hdl/llbs_queue.sv
// Short register queue that decouples the sampler front from its back end.
// Depends on llbs_pkg for the layer item type.
`timescale 1ns / 1ps
`include "layered_lightmap_bilinear_sample_macros.svh"

module llbs_queue #(
  parameter int unsigned Depth = llbs_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  llbs_pkg::layer_t entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output llbs_pkg::layer_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  llbs_pkg::layer_t slot_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  count_q;
  logic             do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign entry_o = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `LLBS_ASSERT(a_no_overflow, push_i |-> !full_o, "push into a full queue")
  `LLBS_ASSERT(a_fill_tracks, push_i && !do_pop |=> count_q == $past(count_q) + CntW'(1),
               "fill count out of step")

endmodule

// File: hdl/llbs_back.sv
// Back end of the lightmap sampler: scales and accumulates the corner sums,
// then interpolates along s and t and holds the result. Depends on llbs_pkg.
`timescale 1ns / 1ps
`include "layered_lightmap_bilinear_sample_macros.svh"

module llbs_back (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               valid_i,
  input  llbs_pkg::layer_t                                   entry_i,
  output logic                                               pop_o,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output logic [llbs_pkg::NumChan-1:0][llbs_pkg::LevelW-1:0] levels_o
);

  typedef enum logic [2:0] {
    BK_IDLE   = 3'b001,
    BK_LERP_S = 3'b010,
    BK_LERP_T = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  llbs_pkg::sum_t [llbs_pkg::NumChan-1:0][llbs_pkg::NumCorners-1:0] sums_q, sums_d;
  llbs_pkg::sum_t [llbs_pkg::NumChan-1:0] top_q, top_d, bot_q, bot_d;
  llbs_pkg::sum_t [llbs_pkg::NumChan-1:0] level_q, level_d;
  logic [llbs_pkg::FracW-1:0] s_frac_q, s_frac_d, t_frac_q, t_frac_d;
  logic out_valid_q, out_valid_d;
  logic load;

  assign pop_o       = (state_q == BK_IDLE) && valid_i;
  assign load        = (state_q == BK_LERP_T) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign levels_o    = level_q;

  always_comb begin
    logic [llbs_pkg::ProdW-1:0] prod;
    state_d     = state_q;
    sums_d      = sums_q;
    top_d       = top_q;
    bot_d       = bot_q;
    level_d     = level_q;
    s_frac_d    = s_frac_q;
    t_frac_d    = t_frac_q;
    out_valid_d = out_valid_q && !out_ready_i;
    prod        = '0;
    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          if (entry_i.accum) begin
            for (int c = 0; c < llbs_pkg::NumChan; c++) begin
              for (int k = 0; k < llbs_pkg::NumCorners; k++) begin
                prod = entry_i.corners[k][c*llbs_pkg::ChanW +: llbs_pkg::ChanW]
                       * entry_i.scale;
                sums_d[c][k] = sums_q[c][k] + llbs_pkg::SumW'(prod);
              end
            end
          end
          if (entry_i.last) begin
            s_frac_d = entry_i.s_frac;
            t_frac_d = entry_i.t_frac;
            state_d  = BK_LERP_S;
          end
        end
      end
      BK_LERP_S: begin
        for (int c = 0; c < llbs_pkg::NumChan; c++) begin
          top_d[c] = llbs_pkg::lerp(sums_q[c][llbs_pkg::CornerTL],
                                    sums_q[c][llbs_pkg::CornerTR], s_frac_q);
          bot_d[c] = llbs_pkg::lerp(sums_q[c][llbs_pkg::CornerBL],
                                    sums_q[c][llbs_pkg::CornerBR], s_frac_q);
        end
        state_d = BK_LERP_T;
      end
      BK_LERP_T: begin
        // Waits here while an earlier result is still unclaimed.
        if (load) begin
          for (int c = 0; c < llbs_pkg::NumChan; c++) begin
            level_d[c] = llbs_pkg::lerp(top_q[c], bot_q[c], t_frac_q);
          end
          sums_d      = '0;
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    bot_q    <= bot_d;
    level_q  <= level_d;
    s_frac_q <= s_frac_d;
    t_frac_q <= t_frac_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      sums_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sums_q      <= sums_d;
      out_valid_q <= out_valid_d;
    end
  end

  `LLBS_ASSERT(a_pop_when_idle, pop_o |-> state_q == BK_IDLE, "pop outside idle")
  `LLBS_ASSERT(a_s_then_t, state_q == BK_LERP_S |=> state_q == BK_LERP_T, "lerp order broken")
  `LLBS_ASSERT(a_load_clears, load |=> out_valid_q && sums_q == '0,
               "result load did not clear the sums")
  `LLBS_ASSERT(a_hold_stalled, out_valid_q && !out_ready_i |=> out_valid_q,
               "pending result dropped")

endmodule

// File: hdl/layered_lightmap_bilinear_sample.sv
// Top level of the layered lightmap bilinear sampler.
// Depends on llbs_pkg, llbs_front, llbs_queue and llbs_back.
//
// Usage: every input item is one light-style layer of one sample point. It
// carries the four RGB corner texels, the layer scale, the s and t fractions
// and, on tlast, the flag for the final layer of the sample. Each layer's
// corners are scaled and summed per corner and channel; layers beyond
// MaxLayers in one sample are counted out and not summed. The final layer
// triggers bilinear interpolation (first along s, then along t, each step
// flooring its sixteenths) and one result item with red, green and blue
// levels in units of 1/256.
// Throughput: layers that are not final stream at one item per cycle while the
// accumulator is idle and the queue has room; a final layer holds the
// accumulator through the accumulate, s step and t step states. A final layer
// accepted with nothing queued ahead of it passes the queue register, those
// states and the output register before tvalid rises on the result channel.
// A two-entry queue sits between the input classifier and the accumulator, and
// the result waits in an output register, so input items are still taken while
// a result is stalled, until the queue fills. A stalled result holds its data
// and freezes the interpolation of the next sample only.
// Reset clears the queue, the layer count, all corner sums and the result
// valid flag; the asynchronous reset does this clearing itself.
`timescale 1ns / 1ps

module layered_lightmap_bilinear_sample #(
  parameter int unsigned MaxLayers = llbs_pkg::MaxLayersDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [23:0] corner_top_left, [47:24] corner_top_right, [71:48] corner_bottom_left,
  // [95:72] corner_bottom_right, [105:96] layer_scale, [109:106] s_fraction,
  // [113:110] t_fraction, [119:114] zero
  input  logic [119:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,  // last_layer
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [19:0] red_level, [39:20] green_level, [59:40] blue_level, [63:60] zero
  output logic [63:0]  m_axis_tdata_o
);

  localparam int unsigned CornersW = llbs_pkg::NumCorners * llbs_pkg::TexelW;
  localparam int unsigned ScaleLo  = CornersW;
  localparam int unsigned SFracLo  = ScaleLo + llbs_pkg::ScaleW;
  localparam int unsigned TFracLo  = SFracLo + llbs_pkg::FracW;
  localparam int unsigned LevelsW  = llbs_pkg::NumChan * llbs_pkg::LevelW;

  // Front-to-queue and queue-to-back handshakes.
  logic             push, full, queue_valid, pop;
  llbs_pkg::layer_t front_entry, back_entry;
  logic [llbs_pkg::NumChan-1:0][llbs_pkg::LevelW-1:0] levels;

  llbs_front #(
    .MaxLayers(MaxLayers)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .corners_i(s_axis_tdata_i[CornersW-1:0]),
    .scale_i  (s_axis_tdata_i[ScaleLo +: llbs_pkg::ScaleW]),
    .s_frac_i (s_axis_tdata_i[SFracLo +: llbs_pkg::FracW]),
    .t_frac_i (s_axis_tdata_i[TFracLo +: llbs_pkg::FracW]),
    .last_i   (s_axis_tlast_i),
    .full_i   (full),
    .ready_o  (s_axis_tready_o),
    .push_o   (push),
    .entry_o  (front_entry)
  );

  llbs_queue #(
    .Depth(llbs_pkg::QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(front_entry),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(queue_valid),
    .entry_o(back_entry)
  );

  llbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (queue_valid),
    .entry_i    (back_entry),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .levels_o   (levels)
  );

  // Red lands in the lowest bits, then green, then blue.
  assign m_axis_tdata_o = {{(64 - LevelsW){1'b0}}, levels};

endmodule

// File: test/testbench.sv
// Self-checking testbench for the layered lightmap bilinear sampler: directed
// layers, then random multi-layer samples with random stalls on both streams.
// Depends on llbs_pkg and layered_lightmap_bilinear_sample.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TexelW     = llbs_pkg::TexelW;
  localparam int unsigned SumW       = llbs_pkg::SumW;
  localparam int unsigned ScaleW     = llbs_pkg::ScaleW;
  localparam int unsigned FracW      = llbs_pkg::FracW;
  localparam int unsigned NumCorners = llbs_pkg::NumCorners;
  localparam int unsigned MaxLayers  = llbs_pkg::MaxLayersDef;
  localparam int unsigned RandomItems = 1900;
  localparam int unsigned CalmAfter   = 1700;
  localparam int unsigned StallLimit  = 5000;

  typedef struct packed {
    logic [FracW-1:0]                  t_frac;
    logic [FracW-1:0]                  s_frac;
    logic [ScaleW-1:0]                 scale;
    logic [NumCorners-1:0][TexelW-1:0] corners;
  } layer_item_t;

  typedef struct packed {
    logic [SumW-1:0] blue;
    logic [SumW-1:0] green;
    logic [SumW-1:0] red;
  } level_t;

  typedef struct packed {
    layer_item_t item;
    logic        last;
    logic        typed;
    level_t      level;
  } layer_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic [119:0] s_data = '0;
  logic         s_last = 1'b0;
  logic         m_ready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [63:0]  m_axis_tdata_o;

  layered_lightmap_bilinear_sample dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the corner sums and the layer count.
  logic [SumW-1:0] red_sum   [NumCorners];
  logic [SumW-1:0] green_sum [NumCorners];
  logic [SumW-1:0] blue_sum  [NumCorners];
  int unsigned     layer_count;

  level_t      level_fifo [$];
  layer_row_t  directed_rows [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  bit          calm = 1'b0;

  task automatic clear_sums();
    for (int k = 0; k < NumCorners; k++) begin
      red_sum[k]   = '0;
      green_sum[k] = '0;
      blue_sum[k]  = '0;
    end
    layer_count = 0;
  endtask

  // a + floor((b - a) * frac / 16), arithmetic shift gives the floor.
  function automatic logic [SumW-1:0] frac_step(logic [SumW-1:0] a, logic [SumW-1:0] b,
                                                logic [FracW-1:0] frac);
    longint sa;
    longint sb;
    longint sf;
    longint v;
    sa = a;
    sb = b;
    sf = frac;
    v = (((sb - sa) * sf) >>> FracW) + sa;
    if (v < 0) v = 0;
    return v[SumW-1:0];
  endfunction

  function automatic logic [SumW-1:0] blend_corners(logic [SumW-1:0] tl, logic [SumW-1:0] tr,
                                                    logic [SumW-1:0] bl, logic [SumW-1:0] br,
                                                    logic [FracW-1:0] sf, logic [FracW-1:0] tf);
    return frac_step(frac_step(tl, tr, sf), frac_step(bl, br, sf), tf);
  endfunction

  // Adds one layer into the shadow sums; returns 1 with the levels on a last layer.
  task automatic predict_layer(input layer_item_t it, input logic last, output bit produced,
                               output level_t lv);
    logic [TexelW-1:0] tx;
    if (layer_count < MaxLayers) begin
      for (int k = 0; k < NumCorners; k++) begin
        tx = it.corners[k];
        red_sum[k]   = red_sum[k]   + SumW'(tx[7:0]   * it.scale);
        green_sum[k] = green_sum[k] + SumW'(tx[15:8]  * it.scale);
        blue_sum[k]  = blue_sum[k]  + SumW'(tx[23:16] * it.scale);
      end
      layer_count++;
    end
    produced = last;
    lv = '0;
    if (last) begin
      lv.red   = blend_corners(red_sum[0], red_sum[1], red_sum[2], red_sum[3],
                               it.s_frac, it.t_frac);
      lv.green = blend_corners(green_sum[0], green_sum[1], green_sum[2], green_sum[3],
                               it.s_frac, it.t_frac);
      lv.blue  = blend_corners(blue_sum[0], blue_sum[1], blue_sum[2], blue_sum[3],
                               it.s_frac, it.t_frac);
      clear_sums();
    end
  endtask

  // Presents one layer and waits for it to be taken. The predicted levels are
  // queued, unless the row carries its own expected levels.
  task automatic send_layer(input layer_row_t row);
    bit     produced;
    level_t lv;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {6'd0, row.item};
    s_last  <= row.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_layer(row.item, row.last, produced, lv);
    if (produced) level_fifo.push_back(row.typed ? row.level : lv);
    items_sent++;
  endtask

  task automatic add_row(input logic [TexelW-1:0] tl, input logic [TexelW-1:0] tr,
                         input logic [TexelW-1:0] bl, input logic [TexelW-1:0] br,
                         input int scale, input int sf, input int tf, input bit last,
                         input bit typed, input int r, input int g, input int b);
    layer_row_t row;
    row.item.corners = {br, bl, tr, tl};
    row.item.scale   = ScaleW'(scale);
    row.item.s_frac  = FracW'(sf);
    row.item.t_frac  = FracW'(tf);
    row.last         = last;
    row.typed        = typed;
    row.level.red    = SumW'(r);
    row.level.green  = SumW'(g);
    row.level.blue   = SumW'(b);
    directed_rows.push_back(row);
  endtask

  function automatic logic [TexelW-1:0] rand_texel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return TexelW'($urandom);
    endcase
  endfunction

  function automatic logic [ScaleW-1:0] rand_scale();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ScaleW'(256);
      2: return '1;
      default: return ScaleW'($urandom_range(0, 1023));
    endcase
  endfunction

  // One sample point: mostly one to four layers, sometimes more than the
  // block takes. Fractions are random on every layer.
  task automatic send_random_sample();
    int unsigned layers;
    layer_row_t  row;
    layers = ($urandom_range(0, 9) < 8) ? $urandom_range(1, MaxLayers)
                                        : $urandom_range(MaxLayers + 1, MaxLayers + 2);
    for (int unsigned n = 0; n < layers; n++) begin
      for (int k = 0; k < NumCorners; k++) row.item.corners[k] = rand_texel();
      row.item.scale  = rand_scale();
      row.item.s_frac = FracW'($urandom);
      row.item.t_frac = FracW'($urandom);
      row.last        = (n == layers - 1);
      row.typed       = 1'b0;
      row.level       = '0;
      send_layer(row);
    end
  endtask

  // Output side: ready in random bursts, held high once the run turns calm.
  initial begin
    @(posedge rst_ni);
    forever begin
      m_ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 16)) @(posedge clk_i);
      if (!calm) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_levels
    level_t want;
    level_t got;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = m_axis_tdata_o[3*SumW-1:0];
      if (level_fifo.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        errors++;
      end else begin
        want = level_fifo.pop_front();
        if (got.red !== want.red) begin
          $display("%0t: red_level expected %0d actual %0d", $realtime, want.red, got.red);
          errors++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green_level expected %0d actual %0d", $realtime, want.green,
                   got.green);
          errors++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue_level expected %0d actual %0d", $realtime, want.blue, got.blue);
          errors++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any item moving on either stream.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    clear_sums();

    // Extremes, no styles, too many layers, single channels, floors both ways.
    add_row('1, '1, '1, '1, 1023, 7, 9, 1, 1, 260865, 260865, 260865);
    add_row('1, '1, '1, '1, 0, 15, 15, 1, 1, 0, 0, 0);
    add_row('0, '0, '0, '0, 1023, 15, 0, 1, 1, 0, 0, 0);
    for (int n = 0; n < MaxLayers; n++) add_row('1, '1, '1, '1, 1023, 15, 15, 0, 0, 0, 0, 0);
    add_row('1, '1, '1, '1, 1023, 3, 12, 1, 1, 1043460, 1043460, 1043460);
    add_row(24'h0000FF, '0, '0, '0, 256, 0, 0, 1, 1, 65280, 0, 0);
    add_row('0, '0, '0, 24'hFF0000, 256, 15, 15, 1, 0, 0, 0, 0);
    add_row(24'h0000FF, '0, '0, '0, 1, 1, 0, 1, 0, 0, 0, 0);
    add_row(24'h00FF00, '0, '0, 24'h00FF00, 512, 8, 8, 0, 0, 0, 0, 0);
    add_row(24'h123456, 24'hABCDEF, 24'h0F0F0F, 24'hF0F0F0, 300, 5, 11, 1, 0, 0, 0, 0);
    add_row(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 341, 5, 10, 1, 0, 0, 0, 0);
    add_row(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 682, 10, 5, 1, 0, 0, 0, 0);
    for (int n = 0; n < MaxLayers - 1; n++)
      add_row(24'h808080, 24'h808080, 24'h808080, 24'h808080, 1023, 0, 0, 0, 0, 0, 0, 0);
    add_row(24'h808080, 24'h808080, 24'h808080, 24'h808080, 1023, 9, 2, 1, 1,
            523776, 523776, 523776);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_layer(directed_rows[i]);

    items_sent = 0;
    while (items_sent < RandomItems) begin
      if (items_sent >= CalmAfter) calm = 1'b1;
      send_random_sample();
    end
    s_valid <= 1'b0;
    s_last  <= 1'b0;

    while (level_fifo.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
